[sv/b64d_pkg.sv]
// Package for the base64 stream decoder: job record, character codes,
// alphabet mapping and byte packing functions. No dependencies.
package b64d_pkg;

	localparam int CODE_W = 21;

	localparam logic [CODE_W-1:0] CODE_PAD = 21'h00003D;
	localparam logic [CODE_W-1:0] CODE_CR  = 21'h00000D;
	localparam logic [CODE_W-1:0] CODE_LF  = 21'h00000A;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_SLASH   = 8'h2F;

	localparam logic [7:0] VAL_LOWER_BASE = 8'd26;
	localparam logic [7:0] VAL_DIGIT_BASE = 8'd52;
	localparam logic [7:0] VAL_PLUS       = 8'd62;
	localparam logic [7:0] VAL_SLASH      = 8'd63;
	localparam logic [7:0] VAL_BAD        = 8'hFF;

	localparam logic [7:0] MASK_30 = 8'h30;
	localparam logic [7:0] MASK_0F = 8'h0F;
	localparam logic [7:0] MASK_3C = 8'h3C;
	localparam logic [7:0] MASK_03 = 8'h03;

	typedef logic [2:0][7:0] byte3_t;

	// One queued job: the results caused by one input character
	typedef struct packed {
		byte3_t     bytes;     // bytes[0] goes out first
		logic [1:0] count;     // number of results, 1..3
		logic       has_data;  // 0 for the empty end-of-text result
		logic       done;      // last result closes the text
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [7:0] map_char(input logic [7:0] c);
		logic [7:0] v;
		v = VAL_BAD;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			v = c - CHAR_UPPER_A;
		end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			v = c - CHAR_LOWER_A + VAL_LOWER_BASE;
		end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
			v = c - CHAR_DIGIT_0 + VAL_DIGIT_BASE;
		end else if (c == CHAR_PLUS) begin
			v = VAL_PLUS;
		end else if (c == CHAR_SLASH) begin
			v = VAL_SLASH;
		end
		return v;
	endfunction

	// Pack four 6-bit values into three bytes; sums wrap at 8 bits
	function automatic byte3_t make_bytes(input logic [7:0] v0, input logic [7:0] v1,
	                                      input logic [7:0] v2, input logic [7:0] v3);
		byte3_t b;
		b[0] = {v0[5:0], 2'b00} + ((v1 & MASK_30) >> 4);
		b[1] = {v1[3:0], 4'b0000} + ((v2 & MASK_3C) >> 2);
		b[2] = {v2[1:0], 6'b000000} + v3;
		return b;
	endfunction

endpackage

[sv/b64d_if.sv]
// Channel interfaces of the base64 stream decoder: character input and
// decoded byte output. Depends on b64d_pkg.
interface b64d_char_if;
	logic                         valid;
	logic                         ready;
	logic [b64d_pkg::CODE_W-1:0]  code_unit;
	logic                         end_of_text;

	modport source(output valid, output code_unit, output end_of_text, input ready);
	modport sink(input valid, input code_unit, input end_of_text, output ready);
endinterface

interface b64d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       text_done;
	logic       run_last;

	modport source(output valid, output data_byte, output byte_valid, output text_done,
	               output run_last, input ready);
	modport sink(input valid, input data_byte, input byte_valid, input text_done,
	             input run_last, output ready);
endinterface

[sv/b64d_front.sv]
// Front end: accepts characters, tracks the open group and pad state, and turns each
// character closing a group or the text into a job of up to three results. Depends on b64d_pkg.
module b64d_front (
	input  logic                clk,
	input  logic                arst_n,
	b64d_char_if.sink           char_in,
	input  b64d_pkg::q_stat_t   q_stat,
	output logic                push,
	output b64d_pkg::job_t      push_job
);

	logic [2:0][7:0] held_q;
	logic [1:0]      cnt_q;
	logic            pad_q;

	logic            accept;
	logic            is_pad;
	logic            is_skip;
	logic            proc;
	logic            grp;
	logic [7:0]      val;
	logic [2:0][7:0] held_a;
	logic [1:0]      cnt_a;
	logic [7:0]      v2_tail;

	assign char_in.ready = !q_stat.full;
	assign accept        = char_in.valid && char_in.ready;

	assign is_pad  = char_in.code_unit == b64d_pkg::CODE_PAD;
	assign is_skip = (char_in.code_unit == b64d_pkg::CODE_CR) ||
	                 (char_in.code_unit == b64d_pkg::CODE_LF);
	assign proc    = !pad_q && !is_pad && !is_skip;
	assign grp     = proc && (cnt_q == 2'd3);
	assign val     = b64d_pkg::map_char(char_in.code_unit[7:0]);

	always_comb begin
		held_a = held_q;
		cnt_a  = cnt_q;
		if (grp) begin
			cnt_a = 2'd0;
		end else if (proc) begin
			held_a[cnt_q] = val;
			cnt_a         = cnt_q + 2'd1;
		end
	end

	assign v2_tail = (cnt_a == 2'd3) ? held_a[2] : b64d_pkg::VAL_BAD;

	always_comb begin
		push_job          = '0;
		push_job.has_data = 1'b1;
		push_job.done     = char_in.end_of_text;
		if (grp) begin
			push_job.bytes = b64d_pkg::make_bytes(held_q[0], held_q[1], held_q[2], val);
			push_job.count = 2'd3;
		end else if (cnt_a >= 2'd2) begin
			push_job.bytes = b64d_pkg::make_bytes(held_a[0], held_a[1], v2_tail,
			                                      b64d_pkg::VAL_BAD);
			push_job.count = cnt_a - 2'd1;
		end else begin
			// nothing due: a single empty end result
			push_job.count    = 2'd1;
			push_job.has_data = 1'b0;
		end
	end

	assign push = accept && (grp || char_in.end_of_text);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			cnt_q  <= 2'd0;
			pad_q  <= 1'b0;
		end else if (accept) begin
			if (char_in.end_of_text) begin
				held_q <= '0;
				cnt_q  <= 2'd0;
				pad_q  <= 1'b0;
			end else begin
				held_q <= held_a;
				cnt_q  <= cnt_a;
				pad_q  <= pad_q || is_pad;
			end
		end
	end

endmodule

[sv/b64d_queue.sv]
// Job queue between front and back end, built from flops.
// Depends on b64d_pkg.
module b64d_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  b64d_pkg::job_t      push_job,
	input  logic                pop,
	output b64d_pkg::job_t      head,
	output b64d_pkg::q_stat_t   stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	b64d_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign head       = mem_q[rd_q];
	assign stat.full  = cnt_q == CNT_FULL;
	assign stat.empty = cnt_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[sv/b64d_back.sv]
// Back end: holds one job in an output register and sends its results one
// transfer per cycle while byte_out.ready is high. Depends on b64d_pkg.
module b64d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  b64d_pkg::job_t      head,
	input  b64d_pkg::q_stat_t   q_stat,
	output logic                pop,
	b64d_byte_if.source         byte_out
);

	b64d_pkg::job_t job_q;
	logic           valid_q;
	logic [1:0]     idx_q;
	logic           take;
	logic           last;

	assign last = idx_q == (job_q.count - 2'd1);
	assign take = valid_q && byte_out.ready;
	// refill when nothing is held or as the final result of the held job leaves
	assign pop  = !q_stat.empty && (!valid_q || (take && last));

	assign byte_out.valid      = valid_q;
	assign byte_out.data_byte  = job_q.has_data ? job_q.bytes[idx_q] : 8'h00;
	assign byte_out.byte_valid = job_q.has_data;
	assign byte_out.run_last   = last;
	assign byte_out.text_done  = job_q.done && last;

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (pop) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (take) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

[sv/base64_stream_decoder.sv]
// Top level of the base64 stream decoder: front end, job queue, back end.
// Depends on b64d_pkg, b64d_if, b64d_front, b64d_queue, b64d_back.
//
//   channel    dir  payload                                         handshake
//   char_in    in   code_unit[20:0], end_of_text                    valid/ready
//   byte_out   out  data_byte[7:0], byte_valid, text_done, run_last valid/ready
//
// A character is taken every cycle while the job queue has room; a character
// that completes a group or ends the text queues one job.
// The back end sends one result per cycle from its output register while byte_out.ready
// is high, so a full group of four characters yields three results; the queue lets the front end run ahead.
// Reset clears group state, pad flag, queue pointers and count, and the output valid flag and index.
// When the output stalls the queue fills, then char_in.ready drops.
module base64_stream_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	b64d_char_if.sink     char_in,
	b64d_byte_if.source   byte_out
);

	b64d_pkg::job_t    push_job;
	b64d_pkg::job_t    head;
	b64d_pkg::q_stat_t q_stat;
	logic              push;
	logic              pop;

	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_in  (char_in),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	b64d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.byte_out (byte_out)
	);

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("job queue read while empty");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		byte_out.valid && !byte_out.byte_valid |-> byte_out.text_done && byte_out.run_last)
		else $error("empty result that does not close the text");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		byte_out.valid && byte_out.text_done |-> byte_out.run_last)
		else $error("text_done without run_last");
`endif

endmodule
